// ===== hw/rtl/bb3_pkg.sv =====
// shared types and constants of the 3x3 zero-padded box blur
// no dependencies; imported by every module of the block except bb3_ram
`timescale 1ns / 1ps

package bb3_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int COORD_W     = 10;
	localparam int REG_W       = 11;
	localparam int REG_IDX_W   = 1;
	localparam int SUM_W       = 12;
	localparam int PROD_W      = 24;
	localparam int WIN_SIZE    = 3;
	localparam int WIN_CELLS   = WIN_SIZE * WIN_SIZE;
	localparam int LINE_W      = 2 * SAMPLE_W;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FRAME_LIMIT   = 1024;

	localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(9);
	localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(9);

	// round to nearest: (sum + 4) * ceil(2^15 / 9) >> 15, exact for sums below 2^15 - 4
	localparam logic [SUM_W-1:0]  ROUND_BIAS  = SUM_W'(4);
	localparam logic [PROD_W-1:0] RECIP       = PROD_W'(3641);
	localparam int                RECIP_SHIFT = 15;

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef logic [WIN_CELLS-1:0][SAMPLE_W-1:0] window_t;

	// per-item control that travels with the pixel down the pipeline
	typedef struct packed {
		logic               ready;
		logic               keep_top;
		logic               keep_bot;
		logic               keep_left;
		logic               keep_right;
		logic               last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
	} meta_t;

	typedef struct packed {
		logic s1_valid;
		logic fwd;
		logic wr_en;
	} lw_status_t;

endpackage

// ===== hw/rtl/box_blur_3x3_zero_pad_core.sv =====
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   sample, flush
// out      out  out_valid / out_stall mean_value, out_row, out_column, frame_end
// cfg      in   cfg_write_en          cfg_index, cfg_data
//
// one request per clock while in_stall is low; the request that completes a window
// passes line ram read, window shift, sum, then divide into the output register.
// results lag the input by one row plus one pixel; send frame_width + 1 flush requests
// after a frame to drain it. the line ram read-modify-write sets the one-per-clock rate.
// reset clears counters, window and valids; line ram contents start undefined.
// with the output stalled, in_stall rises once the sum and window stages hold results
// and one more request waits in the line stage.
// top level of the 3x3 zero-padded box blur; depends on bb3_pkg and all bb3 modules
`timescale 1ns / 1ps

module box_blur_3x3_zero_pad_core #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [bb3_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bb3_pkg::REG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bb3_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          flush,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bb3_pkg::SAMPLE_W-1:0]  mean_value,
	output logic [bb3_pkg::COORD_W-1:0]   out_row,
	output logic [bb3_pkg::COORD_W-1:0]   out_column,
	output logic                          frame_end
);

	import bb3_pkg::*;

	logic                in_accept;
	logic                item_valid;
	logic [SAMPLE_W-1:0] item_px;
	logic [COORD_W-1:0]  item_col;
	meta_t               item_meta;
	logic                s1_take;
	logic                s2_take;
	logic                s2_valid;
	meta_t               s2_meta;
	window_t             window;
	lw_status_t          lw_status;

	assign in_stall  = !s1_take;
	assign in_accept = in_valid && s1_take;

	bb3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_accept    (in_accept),
		.sample       (sample),
		.flush        (flush),
		.item_valid   (item_valid),
		.item_px      (item_px),
		.item_col     (item_col),
		.item_meta    (item_meta)
	);

	bb3_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_px    (item_px),
		.item_col   (item_col),
		.item_meta  (item_meta),
		.s2_take    (s2_take),
		.s1_take    (s1_take),
		.s2_valid   (s2_valid),
		.s2_meta    (s2_meta),
		.window     (window),
		.status     (lw_status)
	);

	bb3_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.s2_valid   (s2_valid),
		.s2_meta    (s2_meta),
		.window     (window),
		.out_stall  (out_stall),
		.s2_take    (s2_take),
		.out_valid  (out_valid),
		.mean_value (mean_value),
		.out_row    (out_row),
		.out_column (out_column),
		.frame_end  (frame_end)
	);

`ifndef SYNTHESIS
	// the input only stalls when every stage is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the pipeline has room");

	// forwarded line data always belongs to a live stage-one item
	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		lw_status.fwd |-> lw_status.s1_valid)
		else $error("line forwarding without a stage-one item");

	// forwarding is only set by a line write at the same edge as the read
	a_fwd_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lw_status.fwd) |-> $past(lw_status.wr_en))
		else $error("line forwarding without a preceding write");
`endif

endmodule

// ===== hw/rtl/bb3_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bb3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// frame size registers, input and output raster counters, edge masks
// depends on bb3_pkg
`timescale 1ns / 1ps

module bb3_ctrl #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [bb3_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [bb3_pkg::REG_W-1:0]       cfg_data,
	input  logic                            in_accept,
	input  logic [bb3_pkg::SAMPLE_W-1:0]    sample,
	input  logic                            flush,
	output logic                            item_valid,
	output logic [bb3_pkg::SAMPLE_W-1:0]    item_px,
	output logic [bb3_pkg::COORD_W-1:0]     item_col,
	output bb3_pkg::meta_t                  item_meta
);

	import bb3_pkg::*;

	localparam int WIDTH_CAP_I = (MAX_WIDTH < FRAME_LIMIT) ? MAX_WIDTH : FRAME_LIMIT;
	localparam logic [REG_W-1:0] WIDTH_CAP  = REG_W'(WIDTH_CAP_I);
	localparam logic [REG_W-1:0] HEIGHT_CAP = REG_W'(FRAME_LIMIT);

	logic [REG_W-1:0]   width_q;
	logic [REG_W-1:0]   height_q;
	logic [COORD_W-1:0] in_col_q;
	logic [REG_W-1:0]   in_row_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;

	logic [REG_W-1:0] w_eff;
	logic [REG_W-1:0] h_eff;
	logic             draining;
	logic [REG_W-1:0] in_col_inc;
	logic [REG_W-1:0] out_col_inc;
	logic [REG_W-1:0] out_row_inc;
	logic             in_col_wrap;
	logic             out_col_wrap;
	logic             ready;
	logic             keep_bot;
	logic             keep_right;
	logic             last;

	always_comb begin
		w_eff = (width_q == '0) ? REG_W'(1) : width_q;
		if (w_eff > WIDTH_CAP) begin
			w_eff = WIDTH_CAP;
		end
		h_eff = (height_q == '0) ? REG_W'(1) : height_q;
		if (h_eff > HEIGHT_CAP) begin
			h_eff = HEIGHT_CAP;
		end
	end

	// once the whole frame is in, every request drains with a zero sample
	assign draining   = (in_row_q >= h_eff);
	assign item_valid = in_accept && !(flush && !draining);
	assign item_px    = draining ? '0 : sample;
	assign item_col   = in_col_q;

	assign in_col_inc   = {1'b0, in_col_q} + REG_W'(1);
	assign in_col_wrap  = (in_col_inc >= w_eff);
	assign out_col_inc  = {1'b0, out_col_q} + REG_W'(1);
	assign out_row_inc  = {1'b0, out_row_q} + REG_W'(1);
	assign out_col_wrap = (out_col_inc >= w_eff);

	assign ready      = (in_row_q >= REG_W'(2)) ||
	                    ((in_row_q == REG_W'(1)) && (in_col_q != '0));
	assign keep_bot   = (out_row_inc < h_eff);
	assign keep_right = (out_col_inc < w_eff);
	assign last       = !keep_bot && !keep_right;

	always_comb begin
		item_meta.ready      = ready;
		item_meta.keep_top   = (out_row_q != '0);
		item_meta.keep_bot   = keep_bot;
		item_meta.keep_left  = (out_col_q != '0);
		item_meta.keep_right = keep_right;
		item_meta.last       = last;
		item_meta.row        = out_row_q;
		item_meta.column     = out_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (item_valid) begin
			if (ready && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + REG_W'(1);
				end else begin
					in_col_q <= in_col_inc[COORD_W-1:0];
				end
				if (ready) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc[COORD_W-1:0];
					end else begin
						out_col_q <= out_col_inc[COORD_W-1:0];
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/bb3_window.sv =====
// line store read-modify-write with forwarding, and the 3x3 window register
// depends on bb3_pkg and bb3_ram
`timescale 1ns / 1ps

module bb3_window #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic [bb3_pkg::SAMPLE_W-1:0]  item_px,
	input  logic [bb3_pkg::COORD_W-1:0]   item_col,
	input  bb3_pkg::meta_t                item_meta,
	input  logic                          s2_take,
	output logic                          s1_take,
	output logic                          s2_valid,
	output bb3_pkg::meta_t                s2_meta,
	output bb3_pkg::window_t              window,
	output bb3_pkg::lw_status_t           status
);

	import bb3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                s1_valid_q;
	logic [COORD_W-1:0]  col_s1;
	logic [SAMPLE_W-1:0] px_s1;
	meta_t               meta_s1;
	logic                fwd_s1;
	logic [LINE_W-1:0]   fwd_data_s1;
	logic                s2_valid_q;
	meta_t               meta_s2;
	window_t             window_q;

	logic [LINE_W-1:0]   ram_q;
	logic [LINE_W-1:0]   line_s1;
	logic [SAMPLE_W-1:0] upper_s1;
	logic [SAMPLE_W-1:0] middle_s1;
	logic [LINE_W-1:0]   wr_data;
	logic                adv_s1;

	assign adv_s1  = s1_valid_q && s2_take;
	assign s1_take = !s1_valid_q || s2_take;

	// a write and a read of the same column at one edge: take the written word
	assign line_s1   = fwd_s1 ? fwd_data_s1 : ram_q;
	assign upper_s1  = line_s1[LINE_W-1:SAMPLE_W];
	assign middle_s1 = line_s1[SAMPLE_W-1:0];
	// middle row moves up, the new sample becomes the middle row
	assign wr_data   = {middle_s1, px_s1};

	bb3_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (AW'(col_s1)),
		.wr_data (wr_data),
		.rd_en   (item_valid),
		.rd_addr (AW'(item_col)),
		.rd_data (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (item_valid) begin
			s1_valid_q <= 1'b1;
			fwd_s1     <= adv_s1 && (col_s1 == item_col);
		end else if (adv_s1) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid) begin
			col_s1      <= item_col;
			px_s1       <= item_px;
			meta_s1     <= item_meta;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			window_q   <= '0;
		end else if (s2_take) begin
			s2_valid_q <= s1_valid_q;
			if (s1_valid_q) begin
				for (int r = 0; r < WIN_SIZE; r++) begin
					window_q[r*WIN_SIZE]     <= window_q[r*WIN_SIZE + 1];
					window_q[r*WIN_SIZE + 1] <= window_q[r*WIN_SIZE + 2];
				end
				window_q[2] <= upper_s1;
				window_q[5] <= middle_s1;
				window_q[8] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			meta_s2 <= meta_s1;
		end
	end

	assign s2_valid = s2_valid_q;
	assign s2_meta  = meta_s2;
	assign window   = window_q;

	always_comb begin
		status.s1_valid = s1_valid_q;
		status.fwd      = fwd_s1;
		status.wr_en    = adv_s1;
	end

endmodule

// ===== hw/rtl/bb3_mean.sv =====
// masked window sum, divide by nine with rounding, output register
// depends on bb3_pkg
`timescale 1ns / 1ps

module bb3_mean (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s2_valid,
	input  bb3_pkg::meta_t                s2_meta,
	input  bb3_pkg::window_t              window,
	input  logic                          out_stall,
	output logic                          s2_take,
	output logic                          out_valid,
	output logic [bb3_pkg::SAMPLE_W-1:0]  mean_value,
	output logic [bb3_pkg::COORD_W-1:0]   out_row,
	output logic [bb3_pkg::COORD_W-1:0]   out_column,
	output logic                          frame_end
);

	import bb3_pkg::*;

	logic [WIN_SIZE-1:0] row_keep;
	logic [WIN_SIZE-1:0] col_keep;
	logic [SUM_W-1:0]    sum;
	logic                s3_valid_q;
	logic [SUM_W-1:0]    sum_s3;
	logic [COORD_W-1:0]  row_s3;
	logic [COORD_W-1:0]  col_s3;
	logic                last_s3;
	logic                out_valid_q;
	logic                out_take;
	logic                s3_take;
	logic                s2_push;
	logic [SUM_W-1:0]    biased;
	logic [PROD_W-1:0]   product;

	assign out_take = !out_valid_q || !out_stall;
	assign s3_take  = !s3_valid_q || out_take;
	// an item that gives no result leaves s2 without a slot
	assign s2_take  = !s2_valid || !s2_meta.ready || s3_take;
	assign s2_push  = s2_valid && s2_meta.ready && s3_take;

	assign row_keep = {s2_meta.keep_bot, 1'b1, s2_meta.keep_top};
	assign col_keep = {s2_meta.keep_right, 1'b1, s2_meta.keep_left};

	always_comb begin
		sum = '0;
		for (int r = 0; r < WIN_SIZE; r++) begin
			for (int c = 0; c < WIN_SIZE; c++) begin
				if (row_keep[r] && col_keep[c]) begin
					sum = sum + SUM_W'(window[r*WIN_SIZE + c]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s3_take) begin
			s3_valid_q <= s2_push;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_push) begin
			sum_s3  <= sum;
			row_s3  <= s2_meta.row;
			col_s3  <= s2_meta.column;
			last_s3 <= s2_meta.last;
		end
	end

	assign biased  = sum_s3 + ROUND_BIAS;
	assign product = PROD_W'(biased) * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && s3_valid_q) begin
			mean_value <= product[RECIP_SHIFT +: SAMPLE_W];
			out_row    <= row_s3;
			out_column <= col_s3;
			frame_end  <= last_s3;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sim/tb_box_blur_3x3_zero_pad_core.sv =====
// self-checking testbench of the 3x3 zero-padded box blur core
// depends on bb3_pkg and box_blur_3x3_zero_pad_core; predicts each mean in step with the stream
`timescale 1ns / 1ps

module tb_box_blur_3x3_zero_pad_core;
	import bb3_pkg::*;

	localparam int PIPE_SETTLE  = 8;
	localparam int RANDOM_ITEMS = 650;
	localparam int WINDOW_AREA  = 9;
	localparam int ROUND_HALF   = 4;
	localparam int TIMEOUT_NS   = 5_000_000;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean_value;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  column;
		logic                frame_end;
	} blur_result_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_FLUSH, ROW_WIDTH, ROW_HEIGHT} step_kind_t;

	typedef struct packed {
		step_kind_t      kind;
		logic [REG_W-1:0] value;
		logic            typed;
		blur_result_t    want;
	} step_t;

	localparam blur_result_t NONE = '0;

	// 1x1 frames see only the centre pixel; a 2x2 frame of full scale sums 1020 everywhere
	localparam step_t DIRECTED_STEPS [19] = '{
		'{ROW_WIDTH,  11'd0,   1'b0, NONE},
		'{ROW_HEIGHT, 11'd0,   1'b0, NONE},
		'{ROW_FLUSH,  11'd0,   1'b0, NONE},
		'{ROW_PIXEL,  11'd255, 1'b0, NONE},
		'{ROW_FLUSH,  11'd0,   1'b0, NONE},
		'{ROW_FLUSH,  11'd0,   1'b1, '{8'd28, 10'd0, 10'd0, 1'b1}},
		'{ROW_PIXEL,  11'd5,   1'b0, NONE},
		'{ROW_PIXEL,  11'd200, 1'b0, NONE},
		'{ROW_FLUSH,  11'd0,   1'b1, '{8'd1, 10'd0, 10'd0, 1'b1}},
		'{ROW_WIDTH,  11'd2,   1'b0, NONE},
		'{ROW_HEIGHT, 11'd2,   1'b0, NONE},
		'{ROW_PIXEL,  11'd255, 1'b0, NONE},
		'{ROW_FLUSH,  11'd0,   1'b0, NONE},
		'{ROW_PIXEL,  11'd255, 1'b0, NONE},
		'{ROW_PIXEL,  11'd255, 1'b0, NONE},
		'{ROW_PIXEL,  11'd255, 1'b1, '{8'd113, 10'd0, 10'd0, 1'b0}},
		'{ROW_FLUSH,  11'd0,   1'b1, '{8'd113, 10'd0, 10'd1, 1'b0}},
		'{ROW_FLUSH,  11'd0,   1'b1, '{8'd113, 10'd1, 10'd0, 1'b0}},
		'{ROW_FLUSH,  11'd0,   1'b1, '{8'd113, 10'd1, 10'd1, 1'b1}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 flush = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SAMPLE_W-1:0]  mean_value;
	logic [COORD_W-1:0]   out_row;
	logic [COORD_W-1:0]   out_column;
	logic                 frame_end;

	box_blur_3x3_zero_pad_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.flush        (flush),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_value   (mean_value),
		.out_row      (out_row),
		.out_column   (out_column),
		.frame_end    (frame_end)
	);

	// predictor state
	logic [REG_W-1:0]    width_reg;
	logic [REG_W-1:0]    height_reg;
	logic [SAMPLE_W-1:0] older_line [MAX_WIDTH_DEF];
	logic [SAMPLE_W-1:0] newer_line [MAX_WIDTH_DEF];
	logic [SAMPLE_W-1:0] blur_window [WIN_CELLS];
	int unsigned         feed_row, feed_col, emit_row, emit_col;

	blur_result_t means_due [$];
	int unsigned  fault_count = 0;
	int unsigned  work_items = 0;
	int unsigned  burst_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_box_blur_3x3_zero_pad_core NOT OK");
		$finish;
	end

	function automatic int unsigned active_width();
		int unsigned w;
		w = (width_reg == '0) ? 1 : width_reg;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		if (w > FRAME_LIMIT) w = FRAME_LIMIT;
		return w;
	endfunction

	function automatic int unsigned active_height();
		int unsigned h;
		h = (height_reg == '0) ? 1 : height_reg;
		if (h > FRAME_LIMIT) h = FRAME_LIMIT;
		return h;
	endfunction

	function automatic void clear_predictor();
		int k;
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		for (k = 0; k < MAX_WIDTH_DEF; k++) begin
			older_line[k] = '0;
			newer_line[k] = '0;
		end
		for (k = 0; k < WIN_CELLS; k++) blur_window[k] = '0;
		feed_row = 0;
		feed_col = 0;
		emit_row = 0;
		emit_col = 0;
	endfunction

	// advances the predictor by one request; returns 1 when it yields a mean
	function automatic bit predict_mean(input logic [SAMPLE_W-1:0] px_in, input logic is_flush,
			output blur_result_t res);
		int unsigned w, h, col, sum, r, c;
		bit draining, ready, keep_row, keep_col;
		logic [SAMPLE_W-1:0] px;
		w = active_width();
		h = active_height();
		draining = feed_row >= h;
		res = '0;
		if (is_flush && !draining) return 1'b0;
		px = draining ? '0 : px_in;

		col = feed_col % MAX_WIDTH_DEF;
		for (r = 0; r < WIN_SIZE; r++) begin
			blur_window[r * WIN_SIZE]     = blur_window[r * WIN_SIZE + 1];
			blur_window[r * WIN_SIZE + 1] = blur_window[r * WIN_SIZE + 2];
		end
		blur_window[WIN_SIZE - 1]     = older_line[col];
		blur_window[2 * WIN_SIZE - 1] = newer_line[col];
		blur_window[WIN_CELLS - 1]    = px;
		older_line[col] = newer_line[col];
		newer_line[col] = px;

		ready = feed_row >= 2 || (feed_row == 1 && feed_col >= 1);
		feed_col++;
		if (feed_col >= w) begin
			feed_col = 0;
			feed_row++;
		end
		if (!ready) return 1'b0;

		// zero padding: drop window rows and columns that fall outside the frame
		sum = 0;
		for (r = 0; r < WIN_SIZE; r++) begin
			keep_row = !(r == 0 && emit_row == 0) && !(r == 2 && emit_row + 1 >= h);
			for (c = 0; c < WIN_SIZE; c++) begin
				keep_col = !(c == 0 && emit_col == 0) && !(c == 2 && emit_col + 1 >= w);
				if (keep_row && keep_col) sum += blur_window[r * WIN_SIZE + c];
			end
		end

		res.mean_value = SAMPLE_W'((sum + ROUND_HALF) / WINDOW_AREA);
		res.row        = COORD_W'(emit_row);
		res.column     = COORD_W'(emit_col);
		res.frame_end  = (emit_row + 1 >= h) && (emit_col + 1 >= w);
		if (res.frame_end) begin
			feed_row = 0;
			feed_col = 0;
			emit_row = 0;
			emit_col = 0;
		end else begin
			emit_col++;
			if (emit_col >= w) begin
				emit_col = 0;
				emit_row++;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pick_size(input int unsigned typical);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return REG_W'($urandom_range(typical + 1, typical * 3));
			default: return REG_W'($urandom_range(1, typical));
		endcase
	endfunction

	// sends one request in bursts with random gaps, then predicts what it yields
	task automatic push_request(input logic [SAMPLE_W-1:0] s, input logic f, input logic typed,
			input blur_result_t want);
		blur_result_t got;
		bit has;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
			                                         : $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		sample   <= s;
		flush    <= f;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (!(f && feed_row < active_height())) work_items++;
		has = predict_mean(s, f, got);
		if (typed) begin
			if (!has || got !== want) begin
				$error("directed request: predicted %p, listed %p", got, want);
				fault_count++;
			end
			means_due.push_back(want);
		end else if (has) begin
			means_due.push_back(got);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (means_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		wait_drained();
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val;
		else height_reg = val;
	endtask

	task automatic run_frames(input logic [REG_W-1:0] wv, input logic [REG_W-1:0] hv,
			input int unsigned count);
		int unsigned n, k, pixels;
		write_reg(REG_FRAME_WIDTH, wv);
		write_reg(REG_FRAME_HEIGHT, hv);
		for (n = 0; n < count; n++) begin
			// flush with nothing pending
			if ($urandom_range(0, 7) == 0) push_request(pick_sample(), 1'b1, 1'b0, NONE);
			pixels = active_width() * active_height();
			for (k = 0; k < pixels; k++) begin
				if ($urandom_range(0, 11) == 0) push_request(pick_sample(), 1'b1, 1'b0, NONE);
				push_request(pick_sample(), 1'b0, 1'b0, NONE);
			end
			// drain; a sample here only counts as a flush
			while (feed_row != 0 || feed_col != 0) begin
				if ($urandom_range(0, 5) == 0) push_request(pick_sample(), 1'b0, 1'b0, NONE);
				else push_request(pick_sample(), 1'b1, 1'b0, NONE);
			end
		end
	endtask

	// receiver: in random spans, free running, random stalls or a fixed stall pattern
	initial begin : rx_stall
		int unsigned mode, span, k;
		k = 0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(posedge clk);
				k++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= (k % 7) < 4;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		blur_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (means_due.size() == 0) begin
				$error("mean at row %0d column %0d with nothing expected", out_row, out_column);
				fault_count++;
			end else begin
				exp_r = means_due.pop_front();
				if (mean_value !== exp_r.mean_value) begin
					$error("mean_value: expected %0d, got %0d", exp_r.mean_value, mean_value);
					fault_count++;
				end
				if (out_row !== exp_r.row) begin
					$error("out_row: expected %0d, got %0d", exp_r.row, out_row);
					fault_count++;
				end
				if (out_column !== exp_r.column) begin
					$error("out_column: expected %0d, got %0d", exp_r.column, out_column);
					fault_count++;
				end
				if (frame_end !== exp_r.frame_end) begin
					$error("frame_end: expected %0d, got %0d", exp_r.frame_end, frame_end);
					fault_count++;
				end
			end
		end
	end

	initial begin : main
		int i;
		clear_predictor();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(DIRECTED_STEPS); i++) begin
			case (DIRECTED_STEPS[i].kind)
				ROW_WIDTH:  write_reg(REG_FRAME_WIDTH, DIRECTED_STEPS[i].value);
				ROW_HEIGHT: write_reg(REG_FRAME_HEIGHT, DIRECTED_STEPS[i].value);
				default: push_request(DIRECTED_STEPS[i].value[SAMPLE_W-1:0],
					DIRECTED_STEPS[i].kind == ROW_FLUSH, DIRECTED_STEPS[i].typed,
					DIRECTED_STEPS[i].want);
			endcase
		end

		work_items = 0;
		while (work_items < RANDOM_ITEMS) begin
			run_frames(pick_size(12), pick_size(6), $urandom_range(1, 3));
		end

		wait_drained();
		if (fault_count == 0) $display("tb_box_blur_3x3_zero_pad_core OK");
		else $display("tb_box_blur_3x3_zero_pad_core NOT OK");
		$finish;
	end

endmodule
